>>> rtl/ipwc_pkg.sv
// Shared constants, codes and types for the infrared pulse window capture block.
// Used by the lane, the merge unit and the top level; depends on nothing else.
package ipwc_pkg;

    // Sensor lanes that are built; lanes at or above this count read as zero.
    localparam int SENSOR_COUNT = 8;
    localparam int MAX_SENSORS  = 8;

    // Field widths.
    localparam int WIDTH_W     = 24;
    localparam int STEP_W      = 8;
    localparam int WINDOW_W    = 16;
    localparam int COUNT_W     = 4;
    localparam int INDEX_W     = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SAMPLES = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_STEP     = CFG_INDEX_W'(1);

    // Register values after reset.
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(833);
    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(1);

    typedef logic [WIDTH_W-1:0] width_t;
    typedef width_t [MAX_SENSORS-1:0] width_vec_t;

    // Control sent from the sample stage to every lane.
    typedef struct packed {
        logic                load;
        logic                close;
        logic [STEP_W-1:0]   step;
    } lane_ctrl_t;

    // One finished window.
    typedef struct packed {
        logic [COUNT_W-1:0]  active_count;
        logic [INDEX_W-1:0]  strongest_index;
        width_t              strongest_width;
        width_vec_t          widths;
    } result_t;

endpackage

>>> rtl/ir_pulse_window_capture_core.sv
// Infrared pulse window capture: eight sensor lanes accumulate pulse widths over
// a window of samples, and a merge unit reports the widths and the strongest one.
// Throughput: one sample per cycle; a closing sample waits only while the snapshot is full.
// A window's result passes from the lane snapshots through the merge stage register to the output register.
// Reset clears the accumulators, the sample count and all valid flags, and loads
// a window of 833 samples and a step of 1.
module ir_pulse_window_capture_core
    import ipwc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             sensor_levels,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COUNT_W-1:0]     active_count,
    output logic [INDEX_W-1:0]     strongest_index,
    output logic [WIDTH_W-1:0]     strongest_width,
    output logic [WIDTH_W-1:0]     width_0,
    output logic [WIDTH_W-1:0]     width_1,
    output logic [WIDTH_W-1:0]     width_2,
    output logic [WIDTH_W-1:0]     width_3,
    output logic [WIDTH_W-1:0]     width_4,
    output logic [WIDTH_W-1:0]     width_5,
    output logic [WIDTH_W-1:0]     width_6,
    output logic [WIDTH_W-1:0]     width_7
);

    logic [WINDOW_W-1:0] window_samples_reg;
    logic [STEP_W-1:0]   width_step_reg;
    logic [WINDOW_W-1:0] samples_seen_reg;
    logic [WINDOW_W-1:0] samples_seen_next;
    logic [WINDOW_W-1:0] limit;
    logic                close;
    logic                accept;
    logic                snap_vld_reg;
    logic                snap_ready;
    lane_ctrl_t          lane_ctrl;
    width_vec_t          snap_widths;
    result_t             res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_samples_reg <= WINDOW_RESET;
            width_step_reg     <= STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_SAMPLES: window_samples_reg <= cfg_data[WINDOW_W-1:0];
                REG_WIDTH_STEP:     width_step_reg     <= cfg_data[STEP_W-1:0];
                default:            ;
            endcase
        end
    end

    // Window bookkeeping. A zero window length behaves as one sample.
    always_comb
    begin
        limit = (window_samples_reg == '0) ? WINDOW_W'(1) : window_samples_reg;
        close = ({1'b0, samples_seen_reg} + (WINDOW_W + 1)'(1))
              >= {1'b0, limit};
        samples_seen_next = close ? '0 : samples_seen_reg + WINDOW_W'(1);
    end

    // A sample that closes a window needs a free snapshot stage.
    assign in_ready = !close || !snap_vld_reg || snap_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_seen_reg <= '0;
            snap_vld_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                samples_seen_reg <= samples_seen_next;
            end
            snap_vld_reg <= (snap_vld_reg && !snap_ready) || (accept && close);
        end
    end

    assign lane_ctrl.load  = accept;
    assign lane_ctrl.close = close;
    assign lane_ctrl.step  = width_step_reg;

    // Sensor lanes; unbuilt lanes report zero width.
    for (genvar g = 0; g < MAX_SENSORS; g++)
    begin : g_lane
        if (g < SENSOR_COUNT)
        begin : g_used
            ipwc_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (lane_ctrl),
                .level (sensor_levels[g]),
                .snap  (snap_widths[g])
            );
        end
        else
        begin : g_unused
            assign snap_widths[g] = '0;
        end
    end

    ipwc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_valid  (snap_vld_reg),
        .snap_widths (snap_widths),
        .snap_ready  (snap_ready),
        .res         (res),
        .res_valid   (out_valid),
        .res_ready   (out_ready)
    );

    assign active_count    = res.active_count;
    assign strongest_index = res.strongest_index;
    assign strongest_width = res.strongest_width;
    assign width_0         = res.widths[0];
    assign width_1         = res.widths[1];
    assign width_2         = res.widths[2];
    assign width_3         = res.widths[3];
    assign width_4         = res.widths[4];
    assign width_5         = res.widths[5];
    assign width_6         = res.widths[6];
    assign width_7         = res.widths[7];

    // The strongest width is never below any lane's width.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (strongest_width >= width_0) && (strongest_width >= width_1)
            && (strongest_width >= width_2) && (strongest_width >= width_3)
            && (strongest_width >= width_4) && (strongest_width >= width_5)
            && (strongest_width >= width_6) && (strongest_width >= width_7))
        else $error("strongest width below a lane width");

    // A window with no active lane reports index zero and width zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && active_count == '0) |->
            (strongest_width == '0 && strongest_index == '0))
        else $error("empty window reports a strongest lane");

    // The count never exceeds the number of built lanes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_count <= COUNT_W'(SENSOR_COUNT)))
        else $error("active count above lane count");

    // A closing sample is only taken while the snapshot stage can accept it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && close) |=> snap_vld_reg && samples_seen_reg == '0)
        else $error("closing sample lost its snapshot");

endmodule

>>> rtl/ipwc_lane.sv
// One sensor lane: a saturating width accumulator and its end-of-window snapshot.
// Depends on ipwc_pkg.
module ipwc_lane
    import ipwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  logic       level,
    output width_t     snap
);

    logic [WIDTH_W-1:0] acc_reg;
    logic [WIDTH_W-1:0] acc_next;
    logic [WIDTH_W-1:0] snap_reg;
    logic [WIDTH_W:0]   sum;

    // A low level means a pulse is present; add the step and saturate.
    always_comb
    begin
        sum = {1'b0, acc_reg} + (WIDTH_W + 1)'(ctrl.step);
        if (level)
        begin
            acc_next = acc_reg;
        end
        else if (sum[WIDTH_W])
        begin
            acc_next = '1;
        end
        else
        begin
            acc_next = sum[WIDTH_W-1:0];
        end
    end

    // The accumulator clears when a window closes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.load)
        begin
            acc_reg <= ctrl.close ? '0 : acc_next;
        end
    end

    // The final width of a closing window is held for the merge unit.
    always_ff @(posedge clk)
    begin
        if (ctrl.load && ctrl.close)
        begin
            snap_reg <= acc_next;
        end
    end

    assign snap = snap_reg;

endmodule

>>> rtl/ipwc_merge.sv
// Merge unit: counts the active lanes and finds the strongest one in a two-stage
// registered tree, then holds the result for transfer. Depends on ipwc_pkg.
module ipwc_merge
    import ipwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       snap_valid,
    input  width_vec_t snap_widths,
    output logic       snap_ready,
    output result_t    res,
    output logic       res_valid,
    input  logic       res_ready
);

    localparam int PAIRS = MAX_SENSORS / 2;

    logic                     s1_vld_reg;
    width_vec_t               s1_widths_reg;
    width_t [PAIRS-1:0]       s1_best_w_reg;
    logic [PAIRS-1:0][INDEX_W-1:0] s1_best_i_reg;
    logic [PAIRS-1:0][1:0]    s1_cnt_reg;

    width_t [PAIRS-1:0]       pair_w;
    logic [PAIRS-1:0][INDEX_W-1:0] pair_i;
    logic [PAIRS-1:0][1:0]    pair_cnt;

    width_t                   quad_lo_w;
    width_t                   quad_hi_w;
    width_t                   best_w;
    logic [INDEX_W-1:0]       quad_lo_i;
    logic [INDEX_W-1:0]       quad_hi_i;
    logic [INDEX_W-1:0]       best_i;
    logic [COUNT_W-1:0]       count;

    result_t                  res_reg;
    logic                     res_vld_reg;
    logic                     out_go;
    logic                     s1_go;

    // Stage handshakes: a stage loads when it is empty or its contents move on.
    assign out_go     = !res_vld_reg || res_ready;
    assign s1_go      = !s1_vld_reg || out_go;
    assign snap_ready = s1_go;

    // First level: compare neighbouring lanes; the lower index wins a tie.
    always_comb
    begin
        for (int p = 0; p < PAIRS; p++)
        begin
            if (snap_widths[2*p+1] > snap_widths[2*p])
            begin
                pair_w[p] = snap_widths[2*p+1];
                pair_i[p] = INDEX_W'(2*p+1);
            end
            else
            begin
                pair_w[p] = snap_widths[2*p];
                pair_i[p] = INDEX_W'(2*p);
            end
            pair_cnt[p] = 2'({1'b0, snap_widths[2*p] != '0})
                        + 2'({1'b0, snap_widths[2*p+1] != '0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s1_vld_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && snap_valid)
        begin
            s1_widths_reg <= snap_widths;
            s1_best_w_reg <= pair_w;
            s1_best_i_reg <= pair_i;
            s1_cnt_reg    <= pair_cnt;
        end
    end

    // Remaining two levels of the tree and the total count.
    always_comb
    begin
        if (s1_best_w_reg[1] > s1_best_w_reg[0])
        begin
            quad_lo_w = s1_best_w_reg[1];
            quad_lo_i = s1_best_i_reg[1];
        end
        else
        begin
            quad_lo_w = s1_best_w_reg[0];
            quad_lo_i = s1_best_i_reg[0];
        end
        if (s1_best_w_reg[3] > s1_best_w_reg[2])
        begin
            quad_hi_w = s1_best_w_reg[3];
            quad_hi_i = s1_best_i_reg[3];
        end
        else
        begin
            quad_hi_w = s1_best_w_reg[2];
            quad_hi_i = s1_best_i_reg[2];
        end
        if (quad_hi_w > quad_lo_w)
        begin
            best_w = quad_hi_w;
            best_i = quad_hi_i;
        end
        else
        begin
            best_w = quad_lo_w;
            best_i = quad_lo_i;
        end
        count = '0;
        for (int p = 0; p < PAIRS; p++)
        begin
            count = count + COUNT_W'(s1_cnt_reg[p]);
        end
    end

    // Output register; it holds until the result is transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (out_go)
        begin
            res_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_go && s1_vld_reg)
        begin
            res_reg.active_count    <= count;
            res_reg.strongest_index <= best_i;
            res_reg.strongest_width <= best_w;
            res_reg.widths          <= s1_widths_reg;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_vld_reg;

endmodule
